### hdl/dtach_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtach_pkg
// Types and constants shared by the debounced tachometer and its testbench.
// ----------------------------------------------------------------------------
package dtach_pkg;

    localparam int TIME_W    = 32;
    localparam int LIMIT_W   = 8;
    localparam int CPR_W     = 8;
    localparam int FREQ_W    = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int DIV_W     = TIME_W + CPR_W;
    localparam int STEP_W    = 5;

    localparam logic [FREQ_W-1:0]  FREQ_SCALE = 20'd1000000;
    localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(FREQ_W - 1);

    localparam logic [LIMIT_W-1:0] LIMIT_RST   = 8'd5;
    localparam logic [TIME_W-1:0]  TIMEOUT_RST = 32'd5000;
    localparam logic [CPR_W-1:0]   CPR_RST     = 8'd1;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_REV = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_LOAD
    } dtach_state_t;

endpackage

### hdl/dtach_tick_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtach_tick_if
// Millisecond tick channel: time stamp and raw sensor sample.
// ----------------------------------------------------------------------------
interface dtach_tick_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        sensor_level;

    modport source (output valid, output now_ms, output sensor_level, input ready);
    modport sink   (input valid, input now_ms, input sensor_level, output ready);
endinterface

### hdl/dtach_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtach_result_if
// Result channel: debounced level, edge flag, period and frequency.
// ----------------------------------------------------------------------------
interface dtach_result_if;
    logic        valid;
    logic        ready;
    logic        clean_level;
    logic        edge_seen;
    logic [31:0] period_ms;
    logic [19:0] freq_millihz;

    modport source (output valid, output clean_level, output edge_seen,
                    output period_ms, output freq_millihz, input ready);
    modport sink   (input valid, input clean_level, input edge_seen,
                    input period_ms, input freq_millihz, output ready);
endinterface

### hdl/debounced_tachometer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_tachometer
// Integrating debounce of a tachometer pin, falling-edge period capture and
// frequency in millihertz from a shared restoring divider.
//
//   channel   dir   handshake          payload
//   tick      in    valid/ready        now_ms, sensor_level
//   result    out   valid/ready        clean_level, edge_seen, period_ms,
//                                      freq_millihz
//   cfg       in    cfg_wr_en          cfg_index, cfg_data
//
// a tick that needs a division reaches the result register through check,
// multiply, 20 divider steps and load; one with a held or timed-out
// frequency goes from check straight to load, and idle follows the load.
// the divider has a single 41-bit subtractor. the next request is taken as
// soon as the result is loaded, while the result still waits; a stalled
// result blocks only the next load. reset clears control, debounce, edge and
// output-frequency state and loads register defaults, not the datapath.
// ----------------------------------------------------------------------------
module debounced_tachometer (
    input  logic                             clk,
    input  logic                             rst_n,
    dtach_tick_if.sink                       tick,
    dtach_result_if.source                   result,
    input  logic                             cfg_wr_en,
    input  logic [dtach_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dtach_pkg::CFG_DAT_W-1:0]  cfg_data
);
    import dtach_pkg::*;

    dtach_state_t        state_reg, state_next;

    logic [LIMIT_W-1:0]  limit_reg;
    logic [TIME_W-1:0]   timeout_reg;
    logic [CPR_W-1:0]    cpr_reg;

    logic [LIMIT_W-1:0]  agree_reg, agree_next;
    logic                level_reg, level_next;
    logic                level_before_reg;
    logic [TIME_W-1:0]   period_reg, period_next;
    logic [TIME_W-1:0]   edge_time_reg, edge_time_next;
    logic                edge_reg, edge_next;
    logic [TIME_W-1:0]   now_reg;

    logic [TIME_W-1:0]   span_reg, span_next;
    logic [DIV_W-1:0]    divisor_reg, divisor_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [FREQ_W-1:0]   quo_reg, quo_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_level_reg, out_edge_reg;
    logic [TIME_W-1:0]   out_period_reg;
    logic [FREQ_W-1:0]   out_freq_reg;
    logic                out_load;

    logic                in_fire;
    logic                slot_free;
    logic [TIME_W-1:0]   elapsed;
    logic [CPR_W-1:0]    cpr_eff;
    logic [DIV_W:0]      trial;
    logic [DIV_W:0]      trial_diff;

    assign in_fire   = tick.valid && tick.ready;
    assign slot_free = !out_valid_reg || result.ready;
    assign elapsed   = now_reg - edge_time_reg;
    assign cpr_eff   = (cpr_reg == '0) ? CPR_W'(1) : cpr_reg;
    assign trial      = {rem_reg, quo_reg[FREQ_W-1]};
    assign trial_diff = trial - {1'b0, divisor_reg};

    assign tick.ready          = (state_reg == ST_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.clean_level  = out_level_reg;
    assign result.edge_seen    = out_edge_reg;
    assign result.period_ms    = out_period_reg;
    assign result.freq_millihz = out_freq_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= LIMIT_RST;
            timeout_reg <= TIMEOUT_RST;
            cpr_reg     <= CPR_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE_LIMIT: limit_reg   <= cfg_data[LIMIT_W-1:0];
                REG_TIMEOUT_MS:     timeout_reg <= cfg_data[TIME_W-1:0];
                REG_COUNTS_PER_REV: cpr_reg     <= cfg_data[CPR_W-1:0];
                default:            ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_fire) state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (period_reg == '0 || elapsed > timeout_reg)
                    state_next = ST_LOAD;
                else
                    state_next = ST_MUL;
            end
            ST_MUL:   state_next = ST_DIV;
            ST_DIV:   if (step_reg == LAST_STEP) state_next = ST_LOAD;
            ST_LOAD:  if (slot_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // debounce and edge capture on request
    always_comb
    begin
        agree_next     = agree_reg;
        level_next     = level_reg;
        period_next    = period_reg;
        edge_time_next = edge_time_reg;
        edge_next      = 1'b0;
        if (!tick.sensor_level)
        begin
            if (agree_reg < limit_reg)
                agree_next = agree_reg + LIMIT_W'(1);
            else
                level_next = 1'b1;
        end
        else
        begin
            if (agree_reg != '0)
                agree_next = agree_reg - LIMIT_W'(1);
            else
                level_next = 1'b0;
        end
        if (level_before_reg && !level_next)
        begin
            period_next    = tick.now_ms - edge_time_reg;
            edge_time_next = tick.now_ms;
            edge_next      = 1'b1;
        end
    end

    // shared divider datapath
    always_comb
    begin
        span_next    = span_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        step_next    = step_reg;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE: ;
            ST_CHECK:
            begin
                span_next = (elapsed > period_reg) ? elapsed : period_reg;
                if (period_reg == '0)
                    quo_next = out_freq_reg;
                else if (elapsed > timeout_reg)
                    quo_next = '0;
            end
            ST_MUL:
            begin
                divisor_next = DIV_W'(span_reg) * DIV_W'(cpr_eff);
                rem_next     = '0;
                quo_next     = FREQ_SCALE;
                step_next    = '0;
            end
            ST_DIV:
            begin
                if (!trial_diff[DIV_W])
                begin
                    rem_next = trial_diff[DIV_W-1:0];
                    quo_next = {quo_reg[FREQ_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[DIV_W-1:0];
                    quo_next = {quo_reg[FREQ_W-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
            end
            ST_LOAD:  out_load = slot_free;
            default:  ;
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            agree_reg        <= '0;
            level_reg        <= 1'b0;
            level_before_reg <= 1'b0;
            period_reg       <= '0;
            edge_time_reg    <= '0;
            edge_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_freq_reg     <= '0;
            step_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            if (in_fire)
            begin
                agree_reg        <= agree_next;
                level_reg        <= level_next;
                level_before_reg <= level_next;
                period_reg       <= period_next;
                edge_time_reg    <= edge_time_next;
                edge_reg         <= edge_next;
            end
            if (out_load)
                out_freq_reg <= quo_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            now_reg <= tick.now_ms;
        span_reg    <= span_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        if (out_load)
        begin
            out_level_reg  <= level_reg;
            out_edge_reg   <= edge_reg;
            out_period_reg <= period_reg;
        end
    end

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == ST_CHECK)
        else $error("request did not start the sequencer");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> divisor_reg != '0)
        else $error("divider started with zero divisor");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && step_reg == LAST_STEP) |=> state_reg == ST_LOAD)
        else $error("divider overran its step count");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("loaded result not presented");

    a_freq_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_freq_reg <= FREQ_SCALE)
        else $error("frequency above full scale");

endmodule

### verif/tb_debounced_tachometer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_debounced_tachometer
// Self-checking bench for the debounced tachometer. A bursty driver sends
// millisecond tick requests from a queue. Each accepted tick is run through
// a cycle-free model of the debounce counter, the falling-edge period
// capture and the millihertz frequency, and the outcome is queued. A monitor
// behind a stalling receiver checks every reading against that queue in
// order. Directed ticks hit the limit, wrap, zero-period and timeout corners.
// Random phases then run pulse trains with noise and time jumps under a
// range of register settings.
// ----------------------------------------------------------------------------
module tb_debounced_tachometer;

    import dtach_pkg::*;

    typedef struct packed {
        logic [TIME_W-1:0] t;
        logic              raw;
    } tick_req_t;

    typedef struct packed {
        logic              clean;
        logic              edge_hit;
        logic [TIME_W-1:0] period;
        logic [FREQ_W-1:0] freq;
    } reading_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    dtach_tick_if   tick_ch ();
    dtach_result_if res_ch ();

    debounced_tachometer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .result    (res_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    tick_req_t pending_ticks[$];
    reading_t  readings_due[$];

    logic [LIMIT_W-1:0] lim_cfg;
    logic [TIME_W-1:0]  timeout_cfg;
    logic [CPR_W-1:0]   cpr_cfg;

    logic [LIMIT_W-1:0] deb_count;
    logic               clean_q;
    logic               clean_prev;
    logic [TIME_W-1:0]  cap_period;
    logic [TIME_W-1:0]  last_edge_ms;
    logic [FREQ_W-1:0]  freq_hold;

    int error_count = 0;
    int readings_seen;

    task automatic compute_reading(input logic [TIME_W-1:0] t_now, input logic raw);
        reading_t           r;
        logic [TIME_W-1:0]  since;
        logic [TIME_W-1:0]  span;
        logic [CPR_W-1:0]   cpr;
        logic [DIV_W-1:0]   divisor;
        r.edge_hit = 1'b0;
        if (!raw)
        begin
            if (deb_count < lim_cfg)
                deb_count = deb_count + 1'b1;
            else
                clean_q = 1'b1;
        end
        else
        begin
            if (deb_count != 0)
                deb_count = deb_count - 1'b1;
            else
                clean_q = 1'b0;
        end
        if (clean_prev && !clean_q)
        begin
            cap_period   = t_now - last_edge_ms;
            last_edge_ms = t_now;
            r.edge_hit   = 1'b1;
        end
        clean_prev = clean_q;
        if (cap_period != 0)
        begin
            since = t_now - last_edge_ms;
            if (since > timeout_cfg)
                freq_hold = '0;
            else
            begin
                span      = (since > cap_period) ? since : cap_period;
                cpr       = (cpr_cfg == 0) ? CPR_W'(1) : cpr_cfg;
                divisor   = DIV_W'(span) * DIV_W'(cpr);
                freq_hold = FREQ_W'(DIV_W'(FREQ_SCALE) / divisor);
            end
        end
        r.clean  = clean_q;
        r.period = cap_period;
        r.freq   = freq_hold;
        readings_due.push_back(r);
    endtask

    // sender: bursts and gaps, valid held until taken
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_ch.valid        <= 1'b0;
            tick_ch.now_ms       <= '0;
            tick_ch.sensor_level <= 1'b1;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!tick_ch.valid || tick_ch.ready)
        begin
            if (tick_ch.valid)
            begin
                compute_reading(tick_ch.now_ms, tick_ch.sensor_level);
                void'(pending_ticks.pop_front());
            end
            if (burst_left == 0 && gap_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            end
            if (gap_left != 0 || pending_ticks.size() == 0)
            begin
                if (gap_left != 0)
                    gap_left--;
                tick_ch.valid <= 1'b0;
            end
            else
            begin
                burst_left--;
                tick_ch.valid        <= 1'b1;
                tick_ch.now_ms       <= pending_ticks[0].t;
                tick_ch.sensor_level <= pending_ticks[0].raw;
            end
        end
    end

    // receiver: segments of stall patterns plus one long hold-off
    int          seg_left;
    int          stall_mode;
    logic [15:0] stall_pat;
    int          hold_left;
    bit          hold_done;
    logic        rdy;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            seg_left  = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (hold_left != 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (readings_seen >= 400 && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = 300;
                rdy = 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left   = $urandom_range(20, 200);
                    stall_mode = $urandom_range(0, 3);
                    stall_pat  = 16'($urandom);
                end
                seg_left--;
                case (stall_mode)
                    0: rdy = 1'b1;
                    1: rdy = 1'($urandom_range(0, 1));
                    2: rdy = ($urandom_range(0, 9) != 0);
                    default:
                    begin
                        rdy = stall_pat[0];
                        stall_pat = {stall_pat[0], stall_pat[15:1]};
                    end
                endcase
            end
            res_ch.ready <= rdy;
        end
    end

    // monitor
    reading_t got;
    reading_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            readings_seen <= 0;
        else if (res_ch.valid && res_ch.ready)
        begin
            readings_seen <= readings_seen + 1;
            got = {res_ch.clean_level, res_ch.edge_seen, res_ch.period_ms, res_ch.freq_millihz};
            if (readings_due.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: unexpected reading level %0b edge %0b period %0d freq %0d",
                             $time, got.clean, got.edge_hit, got.period, got.freq);
            end
            else
            begin
                want = readings_due.pop_front();
                if (got.clean !== want.clean || got.edge_hit !== want.edge_hit ||
                    got.period !== want.period || got.freq !== want.freq)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"%0t: mismatch exp/act level %0b/%0b edge %0b/%0b ",
                                  "period %0d/%0d freq %0d/%0d"}, $time,
                                 want.clean, got.clean, want.edge_hit, got.edge_hit,
                                 want.period, got.period, want.freq, got.freq);
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_DEBOUNCE_LIMIT: lim_cfg     = data[LIMIT_W-1:0];
            REG_TIMEOUT_MS:     timeout_cfg = data[TIME_W-1:0];
            REG_COUNTS_PER_REV: cpr_cfg     = data[CPR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic close_writes;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [LIMIT_W-1:0] lim, input logic [TIME_W-1:0] tmo,
                                  input logic [CPR_W-1:0] cpr);
        write_reg(REG_DEBOUNCE_LIMIT, CFG_DAT_W'(lim));
        write_reg(REG_TIMEOUT_MS, tmo);
        write_reg(REG_COUNTS_PER_REV, CFG_DAT_W'(cpr));
        close_writes;
    endtask

    task automatic wait_drained;
        do
            @(negedge clk);
        while (pending_ticks.size() != 0 || readings_due.size() != 0 || tick_ch.valid);
        repeat (4) @(negedge clk);
    endtask

    task automatic queue_tick(input logic [TIME_W-1:0] t, input logic raw);
        pending_ticks.push_back('{t: t, raw: raw});
    endtask

    initial
    begin
        logic [LIMIT_W-1:0] lim;
        logic [TIME_W-1:0]  tmo;
        logic [CPR_W-1:0]   cpr;
        logic [TIME_W-1:0]  t;
        logic               raw;
        logic               lvl;
        int                 i;
        int                 ph;
        int                 n;
        int                 run;
        int                 lo_len;
        int                 hi_len;
        int                 noise;
        int                 pick;
        bit                 noisy;

        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_DEBOUNCE_LIMIT;
        cfg_data  <= '0;
        lim_cfg      = LIMIT_RST;
        timeout_cfg  = TIMEOUT_RST;
        cpr_cfg      = CPR_RST;
        deb_count    = '0;
        clean_q      = 1'b0;
        clean_prev   = 1'b0;
        cap_period   = '0;
        last_edge_ms = '0;
        freq_hold    = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // instant debounce, full-scale frequency, same-ms edge, time wrap
        apply_settings(8'd0, 32'hFFFF_FFFF, 8'd0);
        queue_tick(32'd0, 1'b0);
        queue_tick(32'd1, 1'b1);
        queue_tick(32'd1, 1'b0);
        queue_tick(32'd1, 1'b1);
        queue_tick(32'd2, 1'b0);
        queue_tick(32'd3, 1'b1);
        queue_tick(32'hFFFF_FFFE, 1'b0);
        queue_tick(32'hFFFF_FFFF, 1'b1);
        queue_tick(32'hFFFF_FFFF, 1'b0);
        queue_tick(32'd3, 1'b1);
        wait_drained;

        // zero timeout and the largest pulse count
        apply_settings(8'd0, 32'd0, 8'd255);
        queue_tick(32'h8000_0001, 1'b0);
        queue_tick(32'h8000_0003, 1'b1);
        queue_tick(32'h8000_0004, 1'b1);
        queue_tick(32'h8000_0005, 1'b0);
        queue_tick(32'h8000_0007, 1'b1);
        wait_drained;

        // limit dropped below the running count
        apply_settings(8'd255, 32'd5000, 8'd1);
        for (i = 0; i < 3; i++)
            queue_tick(32'h7FFF_FFF0 + i, 1'b0);
        wait_drained;
        write_reg(REG_DEBOUNCE_LIMIT, CFG_DAT_W'(2));
        close_writes;
        for (i = 0; i < 5; i++)
            queue_tick(32'h7FFF_FFF3 + i, i != 0);
        wait_drained;

        // full-length debounce at the top limit
        apply_settings(8'd255, 32'hFFFF_FFFF, 8'd3);
        t = $urandom;
        for (i = 0; i < 600; i++)
            queue_tick(t + i, (i >= 280 && i < 560));
        wait_drained;

        for (ph = 0; ph < 11; ph++)
        begin
            case ($urandom_range(0, 5))
                0: lim = 8'd0;
                1: lim = 8'd1;
                5: lim = LIMIT_W'($urandom_range(9, 20));
                default: lim = LIMIT_W'($urandom_range(2, 8));
            endcase
            case ($urandom_range(0, 4))
                0: tmo = 32'd0;
                1: tmo = $urandom_range(1, 40);
                2: tmo = 32'd5000;
                3: tmo = 32'hFFFF_FFFF;
                default: tmo = $urandom;
            endcase
            case ($urandom_range(0, 4))
                0: cpr = 8'd0;
                1: cpr = 8'd1;
                2: cpr = 8'd255;
                3: cpr = CPR_W'($urandom_range(2, 16));
                default: cpr = CPR_W'($urandom_range(1, 255));
            endcase
            apply_settings(lim, tmo, cpr);

            case ($urandom_range(0, 3))
                0, 1: t = $urandom;
                2: t = 32'hFFFF_FFFF - $urandom_range(0, 60);
                default: t = $urandom_range(0, 100);
            endcase
            noisy  = ($urandom_range(0, 7) == 0);
            lo_len = lim + 1 + $urandom_range(0, 12);
            hi_len = lim + 1 + $urandom_range(0, 12);
            noise  = $urandom_range(0, 10);
            lvl    = 1'b0;
            run    = 0;
            n      = $urandom_range(60, 100);
            for (i = 0; i < n; i++)
            begin
                if (noisy)
                    raw = 1'($urandom_range(0, 1));
                else
                begin
                    if (run == 0)
                    begin
                        lvl = !lvl;
                        run = lvl ? hi_len : lo_len;
                    end
                    run--;
                    raw = lvl ^ ($urandom_range(0, 99) < noise);
                end
                queue_tick(t, raw);
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    t = t;
                else if (pick < 6)
                    t = t + $urandom_range(2, 3000);
                else if (pick < 7)
                    t = t + $urandom;
                else
                    t = t + 1;
            end
            wait_drained;
        end

        repeat (30) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
